>>> sv/slpe_pkg.sv
// Shared types, constants and tables for the status LED pattern engine.
package slpe_pkg;

   localparam int LED_COUNT_DEF        = 8;
   localparam int BLINK_HALF_TICKS_DEF = 25;
   localparam int BREATHE_TICKS_DEF    = 100;

   localparam int FRAME_WRAP  = 100;
   localparam int SINE_STEPS  = 100;
   localparam int FRAME_W     = 7;
   localparam int INDEX_W     = 6;
   localparam int FACTOR_W    = 9;
   localparam int LEVEL_W     = 8;

   localparam logic [FACTOR_W-1:0] FULL_FACTOR = 9'd256;
   localparam logic [LEVEL_W-1:0]  FULL_LEVEL  = 8'd255;

   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_SOLID   = 2'd1,
      MODE_BLINK   = 2'd2,
      MODE_BREATHE = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      mode_type   mode;
      logic [2:0] color;
   } entry_type;

   // One LED read in flight, with the frame's pattern levels.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               last;
      logic               blink_on;
      logic [LEVEL_W-1:0] sine;
   } token_type;

   localparam logic [LEVEL_W-1:0] SINE_TABLE [SINE_STEPS] = '{
      8'd127, 8'd135, 8'd143, 8'd151, 8'd159, 8'd166, 8'd174, 8'd181, 8'd188, 8'd195,
      8'd202, 8'd208, 8'd214, 8'd220, 8'd225, 8'd230, 8'd235, 8'd239, 8'd242, 8'd246,
      8'd248, 8'd250, 8'd252, 8'd253, 8'd254, 8'd255, 8'd254, 8'd253, 8'd252, 8'd250,
      8'd248, 8'd246, 8'd242, 8'd239, 8'd235, 8'd230, 8'd225, 8'd220, 8'd214, 8'd208,
      8'd202, 8'd195, 8'd188, 8'd181, 8'd174, 8'd166, 8'd159, 8'd151, 8'd143, 8'd135,
      8'd127, 8'd119, 8'd111, 8'd103, 8'd95,  8'd88,  8'd80,  8'd73,  8'd66,  8'd59,
      8'd52,  8'd46,  8'd40,  8'd34,  8'd29,  8'd24,  8'd19,  8'd15,  8'd12,  8'd8,
      8'd6,   8'd4,   8'd2,   8'd1,   8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd4,
      8'd6,   8'd8,   8'd12,  8'd15,  8'd19,  8'd24,  8'd29,  8'd34,  8'd40,  8'd46,
      8'd52,  8'd59,  8'd66,  8'd73,  8'd80,  8'd88,  8'd95,  8'd103, 8'd111, 8'd119
   };

   function automatic logic [LEVEL_W-1:0] sine_level(input logic [FRAME_W-1:0] q);
      logic [LEVEL_W-1:0] lvl;
      lvl = 8'd0;
      if (q < 7'(SINE_STEPS)) begin
         lvl = SINE_TABLE[q];
      end
      return lvl;
   endfunction

   // Palette as {red, green, blue}.
   function automatic logic [23:0] palette_rgb(input logic [2:0] color);
      logic [23:0] rgb;
      unique case (color)
         3'd0:    rgb = {8'd255, 8'd0,   8'd0};
         3'd1:    rgb = {8'd255, 8'd128, 8'd0};
         3'd2:    rgb = {8'd255, 8'd255, 8'd0};
         3'd3:    rgb = {8'd0,   8'd255, 8'd0};
         3'd4:    rgb = {8'd0,   8'd0,   8'd255};
         3'd5:    rgb = {8'd75,  8'd0,   8'd130};
         3'd6:    rgb = {8'd148, 8'd0,   8'd211};
         default: rgb = {8'd0,   8'd0,   8'd0};
      endcase
      return rgb;
   endfunction

   // floor(x/255) for x below 65280.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

endpackage

>>> sv/slpe_store.sv
// LED entry memory: mode and color per LED, registered read.
module slpe_store #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  slpe_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output slpe_pkg::entry_type rd_data
);
   import slpe_pkg::*;

   entry_type         entry_mem_ff [DEPTH];
   logic [DEPTH-1:0]  written_ff;
   entry_type         rd_entry_ff;
   logic              rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem_ff[rd_addr];
      end
   end

   // Entries never written read as off / red.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_entry_ff : '0;

endmodule

>>> sv/slpe_shade.sv
// Color pipeline: level and dimming, channel products, divide by 255 into the result register.
module slpe_shade (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tok_valid,
   input  slpe_pkg::token_type                  tok,
   input  slpe_pkg::entry_type                  entry,
   input  logic [slpe_pkg::FACTOR_W-1:0]        factor,
   output logic                                 advance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [slpe_pkg::INDEX_W-1:0]         rsp_out_index,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic                                 rsp_last
);
   import slpe_pkg::*;

   logic                 s1_valid_ff;
   logic [INDEX_W-1:0]   s1_index_ff;
   logic                 s1_last_ff;
   logic [LEVEL_W-1:0]   s1_level_ff;
   logic [2:0]           s1_color_ff;

   logic                 s2_valid_ff;
   logic [INDEX_W-1:0]   s2_index_ff;
   logic                 s2_last_ff;
   logic [15:0]          s2_red_ff;
   logic [15:0]          s2_green_ff;
   logic [15:0]          s2_blue_ff;

   logic                 out_valid_ff;
   logic [INDEX_W-1:0]   out_index_ff;
   logic                 out_last_ff;
   logic [7:0]           out_red_ff;
   logic [7:0]           out_green_ff;
   logic [7:0]           out_blue_ff;

   logic [LEVEL_W-1:0]   level;
   logic [16:0]          dimmed;
   logic [LEVEL_W-1:0]   s1_level_in;
   logic [23:0]          rgb;

   // Hold every stage while a finished item waits at the output.
   assign advance = !out_valid_ff || !rsp_stall;

   always_comb begin
      unique case (entry.mode)
         MODE_OFF:     level = 8'd0;
         MODE_SOLID:   level = FULL_LEVEL;
         MODE_BLINK:   level = tok.blink_on ? FULL_LEVEL : 8'd0;
         MODE_BREATHE: level = tok.sine;
         default:      level = 8'd0;
      endcase
      dimmed      = 17'(level) * 17'(factor);
      s1_level_in = dimmed[15:8];
   end

   assign rgb = palette_rgb(s1_color_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= tok_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_index_ff  <= tok.index;
         s1_last_ff   <= tok.last;
         s1_level_ff  <= s1_level_in;
         s1_color_ff  <= entry.color;

         s2_index_ff  <= s1_index_ff;
         s2_last_ff   <= s1_last_ff;
         s2_red_ff    <= 16'(rgb[23:16]) * 16'(s1_level_ff);
         s2_green_ff  <= 16'(rgb[15:8]) * 16'(s1_level_ff);
         s2_blue_ff   <= 16'(rgb[7:0]) * 16'(s1_level_ff);

         out_index_ff <= s2_index_ff;
         out_last_ff  <= s2_last_ff;
         out_red_ff   <= div255(s2_red_ff);
         out_green_ff <= div255(s2_green_ff);
         out_blue_ff  <= div255(s2_blue_ff);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_red       = out_red_ff;
   assign rsp_green     = out_green_ff;
   assign rsp_blue      = out_blue_ff;

endmodule

>>> sv/status_led_pattern_engine.sv
// Status LED pattern engine: sequencer, frame counters, config register, store and pipeline.
//
//   port group   dir   handshake          carries
//   req_*        in    valid / stall      kind, led_num, indication, color
//   rsp_*        out   valid / stall      out_index, red, green, blue, last
//   csr_*        in    valid / ready      brightness_factor
//
// A set item is taken while the engine is idle and writes the LED store at once.
// A frame tick holds req_stall until one store read per LED has issued; results pass
// the store read register and the s1, s2 and output registers, one per cycle while not stalled.
// Reset clears the store's written bits, the frame counters and sets full brightness.
// rsp_stall, while a result waits at the output, freezes the whole read pipeline and the LED sequencer with it.
module status_led_pattern_engine #(
   parameter int LED_COUNT        = slpe_pkg::LED_COUNT_DEF,
   parameter int BLINK_HALF_TICKS = slpe_pkg::BLINK_HALF_TICKS_DEF,
   parameter int BREATHE_TICKS    = slpe_pkg::BREATHE_TICKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [7:0]                           req_led_num,
   input  logic [1:0]                           req_indication,
   input  logic [2:0]                           req_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [slpe_pkg::INDEX_W-1:0]         rsp_out_index,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [slpe_pkg::FACTOR_W-1:0]        csr_brightness_factor
);
   import slpe_pkg::*;

   localparam int ADDR_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int Q_STEP   = SINE_STEPS / BREATHE_TICKS;
   localparam int R_STEP   = SINE_STEPS % BREATHE_TICKS;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    led_ff, led_in;
   logic [FACTOR_W-1:0]  factor_ff;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [FRAME_W-1:0]   blink_ff, blink_in;
   logic [FRAME_W-1:0]   phase_ff, phase_in;
   logic [FRAME_W-1:0]   sine_q_ff, sine_q_in;
   logic [FRAME_W-1:0]   sine_r_ff, sine_r_in;
   logic                 tok_valid_ff;
   token_type            tok_ff, tok_in;

   logic                 advance;
   logic                 accept;
   logic                 issue;
   logic                 last_led;
   logic                 wr_en;
   entry_type            wr_data;
   entry_type            rd_data;
   logic                 frame_wrap;
   logic [FRAME_W:0]     r_sum;
   logic                 q_carry;

   assign accept   = req_valid && !req_stall;
   assign last_led = (led_ff == ADDR_W'(LED_COUNT - 1));
   assign wr_en    = accept && (req_kind == KIND_SET)
                     && (req_led_num < 8'(LED_COUNT));
   assign wr_data  = '{mode: mode_type'(req_indication), color: req_color};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_TICK)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance && last_led) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = 1'b0;
      issue     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_RUN: begin
            req_stall = 1'b1;
            issue     = advance;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   // LED counter and token for the read being issued.
   always_comb begin
      led_in = led_ff;
      if (accept) begin
         led_in = '0;
      end else if (issue) begin
         led_in = led_ff + 1'b1;
      end
      tok_in.index    = INDEX_W'(led_ff);
      tok_in.last     = last_led;
      tok_in.blink_on = (blink_ff < FRAME_W'(BLINK_HALF_TICKS));
      tok_in.sine     = sine_level(sine_q_ff);
   end

   // Frame counters advance once the final LED of a frame is read.
   always_comb begin
      frame_wrap = (frame_ff == FRAME_W'(FRAME_WRAP - 1));
      frame_in   = frame_wrap ? '0 : frame_ff + 1'b1;
      blink_in   = (frame_wrap || blink_ff == FRAME_W'(2 * BLINK_HALF_TICKS - 1))
                   ? '0 : blink_ff + 1'b1;
      r_sum      = {1'b0, sine_r_ff} + (FRAME_W + 1)'(R_STEP);
      q_carry    = (r_sum >= (FRAME_W + 1)'(BREATHE_TICKS));
      if (frame_wrap || phase_ff == FRAME_W'(BREATHE_TICKS - 1)) begin
         phase_in  = '0;
         sine_q_in = '0;
         sine_r_in = '0;
      end else begin
         phase_in  = phase_ff + 1'b1;
         sine_q_in = sine_q_ff + FRAME_W'(Q_STEP) + FRAME_W'(q_carry);
         sine_r_in = q_carry ? FRAME_W'(r_sum - (FRAME_W + 1)'(BREATHE_TICKS))
                             : r_sum[FRAME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         led_ff       <= '0;
         factor_ff    <= FULL_FACTOR;
         frame_ff     <= '0;
         blink_ff     <= '0;
         phase_ff     <= '0;
         sine_q_ff    <= '0;
         sine_r_ff    <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         led_ff   <= led_in;
         if (csr_valid && csr_ready) begin
            factor_ff <= (csr_brightness_factor > FULL_FACTOR)
                         ? FULL_FACTOR : csr_brightness_factor;
         end
         if (issue && last_led) begin
            frame_ff  <= frame_in;
            blink_ff  <= blink_in;
            phase_ff  <= phase_in;
            sine_q_ff <= sine_q_in;
            sine_r_ff <= sine_r_in;
         end
         if (advance) begin
            tok_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         tok_ff <= tok_in;
      end
   end

   // Writes only land while idle and reads only run during a frame, so no
   // read and write of one entry meet in a cycle.
   slpe_store #(
      .DEPTH  (LED_COUNT),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (req_led_num[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (led_ff),
      .rd_data (rd_data)
   );

   slpe_shade u_shade (
      .clock         (clock),
      .reset         (reset),
      .tok_valid     (tok_valid_ff),
      .tok           (tok_ff),
      .entry         (rd_data),
      .factor        (factor_ff),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last      (rsp_last)
   );

endmodule

>>> tb/tb_status_led_pattern_engine.sv
// Testbench for the status LED pattern engine: directed and random items checked by a predictor.
`timescale 1ns / 1ps

module tb_status_led_pattern_engine;
   import slpe_pkg::*;

   localparam int LEDS          = LED_COUNT_DEF;
   localparam int BLINK_HALF    = BLINK_HALF_TICKS_DEF;
   localparam int BREATHE_LEN   = BREATHE_TICKS_DEF;
   localparam int FRAMES        = 100;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 120;
   localparam int RANDOM_ITEMS  = 270;
   localparam int PHASES        = 5;
   localparam int REPORT_MAX    = 10;
   localparam int TIMEOUT_NS    = 3_000_000;

   typedef enum logic [2:0] {
      HUE_RED, HUE_ORANGE, HUE_YELLOW, HUE_GREEN,
      HUE_BLUE, HUE_INDIGO, HUE_VIOLET, HUE_BLACK
   } hue_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               last;
   } pixel_type;

   // floor(255*(sin(2*pi*q/100)+1)/2) for q = 0..99
   localparam logic [7:0] BREATHE_CURVE [FRAMES] = '{
      127, 135, 143, 151, 159, 166, 174, 181, 188, 195,
      202, 208, 214, 220, 225, 230, 235, 239, 242, 246,
      248, 250, 252, 253, 254, 255, 254, 253, 252, 250,
      248, 246, 242, 239, 235, 230, 225, 220, 214, 208,
      202, 195, 188, 181, 174, 166, 159, 151, 143, 135,
      127, 119, 111, 103, 95,  88,  80,  73,  66,  59,
      52,  46,  40,  34,  29,  24,  19,  15,  12,  8,
      6,   4,   2,   1,   0,   0,   0,   1,   2,   4,
      6,   8,   12,  15,  19,  24,  29,  34,  40,  46,
      52,  59,  66,  73,  80,  88,  95,  103, 111, 119
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_SET;
   logic [7:0]          req_led_num = 8'd0;
   logic [1:0]          req_indication = 2'd0;
   logic [2:0]          req_color = 3'd0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_out_index;
   logic [7:0]          rsp_red;
   logic [7:0]          rsp_green;
   logic [7:0]          rsp_blue;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [FACTOR_W-1:0] csr_brightness_factor = FULL_FACTOR;

   // predictor state
   mode_type            led_mode [LEDS];
   hue_type             led_hue [LEDS];
   int unsigned         frame_no;
   int unsigned         dim_factor;
   pixel_type           pending_pixels [$];

   int unsigned         items_sent;
   int unsigned         ticks_sent;
   int unsigned         pixels_seen;
   int unsigned         factor_writes;
   int unsigned         mismatch_count;
   int unsigned         stray_count;

   bit                  req_jitter;
   bit                  rsp_jitter;
   int unsigned         hold_requests;
   int unsigned         hold_served;
   int unsigned         hold_left;
   int unsigned         stall_left;

   status_led_pattern_engine #(
      .LED_COUNT        (LEDS),
      .BLINK_HALF_TICKS (BLINK_HALF),
      .BREATHE_TICKS    (BREATHE_LEN)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_led_num           (req_led_num),
      .req_indication        (req_indication),
      .req_color             (req_color),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_index         (rsp_out_index),
      .rsp_red               (rsp_red),
      .rsp_green             (rsp_green),
      .rsp_blue              (rsp_blue),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_brightness_factor (csr_brightness_factor)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d pixels still pending", pending_pixels.size());
      $display("status_led_pattern_engine verification failed");
      $finish;
   end

   function automatic int unsigned pick_idle_len();
      return ($urandom_range(0, 19) < 18) ? $urandom_range(1, 3) : $urandom_range(8, 25);
   endfunction

   function automatic int unsigned next_gap();
      if (!req_jitter || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return pick_idle_len();
   endfunction

   function automatic logic [23:0] hue_rgb(input hue_type hue);
      case (hue)
         HUE_RED:    return {8'd255, 8'd0,   8'd0};
         HUE_ORANGE: return {8'd255, 8'd128, 8'd0};
         HUE_YELLOW: return {8'd255, 8'd255, 8'd0};
         HUE_GREEN:  return {8'd0,   8'd255, 8'd0};
         HUE_BLUE:   return {8'd0,   8'd0,   8'd255};
         HUE_INDIGO: return {8'd75,  8'd0,   8'd130};
         HUE_VIOLET: return {8'd148, 8'd0,   8'd211};
         default:    return 24'd0;
      endcase
   endfunction

   function automatic int unsigned pattern_level(input mode_type mode, input int unsigned fc);
      int unsigned q;
      case (mode)
         MODE_SOLID: return 255;
         MODE_BLINK: return ((fc % (2 * BLINK_HALF)) < BLINK_HALF) ? 255 : 0;
         MODE_BREATHE: begin
            q = ((fc % BREATHE_LEN) * FRAMES) / BREATHE_LEN;
            if (q >= FRAMES) begin
               q = FRAMES - 1;
            end
            return BREATHE_CURVE[q];
         end
         default: return 0;
      endcase
   endfunction

   // Update the LED table for a set item, or queue one pixel per LED for a tick.
   task automatic predict_item(input logic kind, input logic [7:0] idx,
                               input logic [1:0] ind, input logic [2:0] col);
      int unsigned f;
      int unsigned lvl;
      logic [23:0] rgb;
      pixel_type   px;
      if (kind == KIND_SET) begin
         if (idx < LEDS) begin
            led_mode[idx] = mode_type'(ind);
            led_hue[idx]  = hue_type'(col);
         end
         return;
      end
      f = (dim_factor > 256) ? 256 : dim_factor;
      for (int i = 0; i < LEDS; i++) begin
         lvl      = (pattern_level(led_mode[i], frame_no) * f) / 256;
         rgb      = hue_rgb(led_hue[i]);
         px.index = INDEX_W'(i);
         px.red   = 8'((rgb[23:16] * lvl) / 255);
         px.green = 8'((rgb[15:8] * lvl) / 255);
         px.blue  = 8'((rgb[7:0] * lvl) / 255);
         px.last  = (i == LEDS - 1);
         pending_pixels.push_back(px);
      end
      frame_no = (frame_no + 1) % FRAMES;
      ticks_sent++;
   endtask

   // Offer one item until taken, then idle for the gap given.
   task automatic send_item(input logic kind, input logic [7:0] idx, input logic [1:0] ind,
                            input logic [2:0] col, input int unsigned gap);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_led_num    <= idx;
      req_indication <= ind;
      req_color      <= col;
      do @(posedge clock); while (req_stall);
      predict_item(kind, idx, ind, col);
      items_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_random_item();
      logic       kind;
      logic [7:0] idx;
      kind = ($urandom_range(0, 9) < 4) ? KIND_TICK : KIND_SET;
      if ($urandom_range(0, 7) == 0) begin
         idx = 8'($urandom_range(0, 255));
      end else begin
         idx = 8'($urandom_range(0, LEDS - 1));
      end
      send_item(kind, idx, 2'($urandom), 3'($urandom), next_gap());
   endtask

   // Drop valid and wait until every pixel is out and the pipeline is quiet.
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_factor(input logic [FACTOR_W-1:0] value);
      @(negedge clock);
      csr_valid             <= 1'b1;
      csr_brightness_factor <= value;
      do @(posedge clock); while (!csr_ready);
      dim_factor = value;
      factor_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_frame();
      send_item(KIND_TICK, 8'd0, 2'd0, 3'd0, 0);
      wait_drain();
   endtask

   task automatic test_modes_and_colors();
      send_item(KIND_SET, 8'd0, MODE_SOLID,   HUE_RED,    0);
      send_item(KIND_SET, 8'd1, MODE_SOLID,   HUE_ORANGE, 1);
      send_item(KIND_SET, 8'd2, MODE_BLINK,   HUE_YELLOW, 0);
      send_item(KIND_SET, 8'd3, MODE_BREATHE, HUE_GREEN,  2);
      send_item(KIND_SET, 8'd4, MODE_SOLID,   HUE_BLUE,   0);
      send_item(KIND_SET, 8'd5, MODE_OFF,     HUE_INDIGO, 0);
      send_item(KIND_SET, 8'd6, MODE_BREATHE, HUE_VIOLET, 0);
      send_item(KIND_SET, 8'd7, MODE_SOLID,   HUE_BLACK,  0);
      // the tick's other fields must not matter
      send_item(KIND_TICK, 8'hFF, MODE_BREATHE, HUE_BLACK, 0);
      wait_drain();
   endtask

   task automatic test_index_range();
      send_item(KIND_SET, 8'(LEDS), MODE_OFF,   HUE_BLACK, 0);
      send_item(KIND_SET, 8'd255,   MODE_OFF,   HUE_BLACK, 0);
      send_item(KIND_SET, 8'd128,   MODE_OFF,   HUE_BLACK, 0);
      send_item(KIND_SET, 8'd64,    MODE_OFF,   HUE_BLACK, 0);
      send_item(KIND_SET, 8'd5,     MODE_BLINK, HUE_INDIGO, 0);
      send_item(KIND_TICK, 8'd0, 2'd0, 3'd0, 0);
      wait_drain();
   endtask

   task automatic test_factor_extremes();
      logic [FACTOR_W-1:0] levels [6];
      levels = '{9'd0, 9'd1, 9'd255, 9'd257, 9'd511, FULL_FACTOR};
      foreach (levels[k]) begin
         write_factor(levels[k]);
         send_item(KIND_TICK, 8'd0, 2'd0, 3'd0, 0);
         wait_drain();
      end
   endtask

   // Hold the output off while the sender keeps offering; then pause until empty, send four random items and drain.
   task automatic test_output_hold_off();
      rsp_jitter = 1'b0;
      req_jitter = 1'b0;
      hold_requests++;
      for (int n = 0; n < 6; n++) begin
         send_item(KIND_TICK, 8'd0, 2'd0, 3'd0, 0);
         send_item(KIND_SET, 8'($urandom_range(0, LEDS - 1)), 2'($urandom), 3'($urandom), 0);
      end
      wait_drain();
      for (int n = 0; n < 4; n++) begin
         send_random_item();
      end
      wait_drain();
   endtask

   task automatic test_random_traffic();
      logic [FACTOR_W-1:0] value;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       value = 9'($urandom_range(0, 511));
            1:       value = FULL_FACTOR;
            2:       value = 9'($urandom_range(1, 255));
            3:       value = 9'd511;
            default: value = 9'($urandom_range(200, 300));
         endcase
         wait_drain();
         write_factor(value);
         // one phase runs with no idling at all
         req_jitter = (phase != 2);
         rsp_jitter = (phase != 2);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            send_random_item();
         end
      end
      wait_drain();
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else if (!rsp_jitter) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_out_index, rsp_red, rsp_green, rsp_blue, rsp_last};
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            stray_count++;
            if (mismatch_count + stray_count <= REPORT_MAX) begin
               $display("unexpected pixel: led %0d rgb %0d %0d %0d last %0b",
                        seen.index, seen.red, seen.green, seen.blue, seen.last);
            end
         end else begin
            want = pending_pixels.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count + stray_count <= REPORT_MAX) begin
                  $display("pixel mismatch: expected led %0d rgb %0d %0d %0d last %0b",
                           want.index, want.red, want.green, want.blue, want.last);
                  $display("                got      led %0d rgb %0d %0d %0d last %0b",
                           seen.index, seen.red, seen.green, seen.blue, seen.last);
               end
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < LEDS; i++) begin
         led_mode[i] = MODE_OFF;
         led_hue[i]  = HUE_RED;
      end
      frame_no   = 0;
      dim_factor = FULL_FACTOR;
      req_jitter = 1'b1;
      rsp_jitter = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_frame();
      test_modes_and_colors();
      test_index_range();
      test_factor_extremes();
      test_output_hold_off();
      test_random_traffic();

      $display("run covered %0d items, %0d frame ticks, %0d pixels, %0d factor writes",
               items_sent, ticks_sent, pixels_seen, factor_writes);
      $display("mismatched pixels %0d, unexpected pixels %0d, left pending %0d",
               mismatch_count, stray_count, pending_pixels.size());
      if (mismatch_count == 0 && stray_count == 0 && pending_pixels.size() == 0) begin
         $display("status_led_pattern_engine verification clean");
      end else begin
         $display("status_led_pattern_engine verification failed");
      end
      $finish;
   end

endmodule
